// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the escaper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

// ===== src/jse_pkg.sv =====
package jse_pkg;

    // One input request and one result byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       empty_string;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       string_end;
    } t_out_item;

    // Eight result bytes, entry 0 goes out first.
    typedef logic [7:0][7:0] t_run8;
    typedef logic [5:0][7:0] t_esc_run;

    localparam int unsigned MaxResults = 8;

    // Characters.
    localparam logic [7:0] C_QUOTE   = 8'h22;
    localparam logic [7:0] C_BSLASH  = 8'h5C;
    localparam logic [7:0] C_LOWER_U = 8'h75;
    localparam logic [7:0] C_LOWER_N = 8'h6E;
    localparam logic [7:0] C_LOWER_T = 8'h74;
    localparam logic [7:0] C_BS      = 8'h08;
    localparam logic [7:0] C_TAB     = 8'h09;
    localparam logic [7:0] C_NL      = 8'h0A;
    localparam logic [7:0] C_FF      = 8'h0C;
    localparam logic [7:0] C_CR      = 8'h0D;
    localparam logic [7:0] C_SPACE   = 8'h20;

    // UTF-8 masks and tags.
    localparam logic [7:0] C_HIGH_BIT  = 8'b1000_0000;
    localparam logic [7:0] C_MASK_CONT = 8'b1100_0000;
    localparam logic [7:0] C_TAG_CONT  = 8'b1000_0000;
    localparam logic [7:0] C_MASK_LEAD2 = 8'b1110_0000;
    localparam logic [7:0] C_TAG_LEAD2  = 8'b1100_0000;
    localparam logic [7:0] C_MASK_LEAD3 = 8'b1111_0000;
    localparam logic [7:0] C_TAG_LEAD3  = 8'b1110_0000;

    // Replacement escape, backslash first.
    localparam t_esc_run C_REPLACEMENT = {8'h44, 8'h46, 8'h46, 8'h46, C_LOWER_U, C_BSLASH};

    // Lower-case hex character for one nibble.
    function automatic logic [7:0] hex_digit(logic [3:0] n);
        logic [7:0] wide;
        wide = {4'h0, n};
        if (n < 4'd10) begin
            return 8'h30 + wide;
        end
        return 8'h57 + wide;
    endfunction

    // Backslash-u escape of a 16-bit code point.
    function automatic t_esc_run u_escape(logic [15:0] cp);
        t_esc_run r;
        r[0] = C_BSLASH;
        r[1] = C_LOWER_U;
        r[2] = hex_digit(cp[15:12]);
        r[3] = hex_digit(cp[11:8]);
        r[4] = hex_digit(cp[7:4]);
        r[5] = hex_digit(cp[3:0]);
        return r;
    endfunction

endpackage

// ===== src/jse_in_if.sv =====
interface jse_in_if;
    import jse_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/jse_out_if.sv =====
interface jse_out_if;
    import jse_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/json_string_escaper.sv =====
// Channel   Dir  Payload                                         Handshake
// i_in      in   data_byte, first_byte, last_byte, empty_string  valid/ready
// o_out     out  out_byte, run_end, string_end                   valid/ready
//
// A request is escaped in the cycle it is accepted into a run buffer of up to
// eight bytes; the buffer feeds an output register one byte per cycle while
// o_out is not stalled. A new request is taken in the cycle the last byte of
// the run moves out, so single-byte runs flow at one request per cycle.
// Reset (i_rst_n low, synchronous) empties buffer and output register and
// clears the decoder state. A stall on o_out holds the output register; the
// buffer then fills and i_in drops ready until the run can drain.
module json_string_escaper (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jse_in_if.sink    i_in,
    jse_out_if.source o_out
);
    import jse_pkg::*;

    // Decoder state
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_cl, n_cl;
    logic        r_ab, n_ab;

    // Run buffer and output register
    t_run8       r_list;
    logic [3:0]  r_left;
    logic [2:0]  r_pos;
    logic        r_close;
    logic        r_ov;
    t_out_item   r_out;

    // Escape results for the incoming request
    t_run8       w_mid;
    logic [2:0]  w_mid_len;
    logic        w_open;
    logic        w_close;
    t_run8       w_list;
    logic [3:0]  w_total;
    logic        w_move;
    logic        w_accept;
    logic [7:0]  w_b;
    logic [15:0] w_acc0;
    logic [1:0]  w_cl0;
    logic        w_ab0;
    logic [15:0] w_acc_sh;
    logic [3:0]  w_j;

    // Handshake
    assign w_move   = (r_left != 4'd0) && (!r_ov || o_out.ready);
    assign i_in.ready = (r_left == 4'd0) || ((r_left == 4'd1) && w_move);
    assign w_accept = i_in.valid && i_in.ready;

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // Escape one request and work out the next decoder state
    always_comb begin
        w_b      = i_in.data.data_byte;
        w_acc0   = i_in.data.first_byte ? 16'h0 : r_acc;
        w_cl0    = i_in.data.first_byte ? 2'd0 : r_cl;
        w_ab0    = i_in.data.first_byte ? 1'b0 : r_ab;
        w_acc_sh = {w_acc0[9:0], w_b[5:0]};
        w_mid     = '0;
        w_mid_len = 3'd0;
        n_acc     = w_acc0;
        n_cl      = w_cl0;
        n_ab      = w_ab0;
        w_open    = i_in.data.first_byte;
        w_close   = 1'b0;

        if (w_ab0) begin
            // drop everything after an error
        end else if (w_cl0 != 2'd0) begin
            if ((w_b & C_MASK_CONT) != C_TAG_CONT) begin
                w_mid     = {16'h0, C_REPLACEMENT};
                w_mid_len = 3'd6;
                n_ab      = 1'b1;
                n_cl      = 2'd0;
            end else begin
                n_acc = w_acc_sh;
                n_cl  = w_cl0 - 2'd1;
                if (w_cl0 == 2'd1) begin
                    w_mid     = {16'h0, u_escape(w_acc_sh)};
                    w_mid_len = 3'd6;
                end
            end
        end else if (w_b == C_BS || w_b == C_FF || w_b == C_CR) begin
            // drop
        end else if (w_b == C_NL) begin
            w_mid[0]  = C_BSLASH;
            w_mid[1]  = C_LOWER_N;
            w_mid_len = 3'd2;
        end else if (w_b == C_TAB) begin
            w_mid[0]  = C_BSLASH;
            w_mid[1]  = C_LOWER_T;
            w_mid_len = 3'd2;
        end else if (((w_b & C_HIGH_BIT) != 8'h0) || (w_b < C_SPACE)) begin
            if ((w_b & C_MASK_LEAD2) == C_TAG_LEAD2) begin
                n_acc = {11'h0, w_b[4:0]};
                n_cl  = 2'd1;
            end else if ((w_b & C_MASK_LEAD3) == C_TAG_LEAD3) begin
                n_acc = {12'h0, w_b[3:0]};
                n_cl  = 2'd2;
            end else begin
                w_mid     = {16'h0, C_REPLACEMENT};
                w_mid_len = 3'd6;
                n_ab      = 1'b1;
            end
        end else if (w_b == C_QUOTE || w_b == C_BSLASH) begin
            w_mid[0]  = C_BSLASH;
            w_mid[1]  = w_b;
            w_mid_len = 3'd2;
        end else begin
            w_mid[0]  = w_b;
            w_mid_len = 3'd1;
        end

        // Close the string; an open sequence gets the replacement first
        if (i_in.data.last_byte) begin
            if (!n_ab && (n_cl != 2'd0)) begin
                w_mid     = {16'h0, C_REPLACEMENT};
                w_mid_len = 3'd6;
            end
            w_close = 1'b1;
            n_acc   = 16'h0;
            n_cl    = 2'd0;
            n_ab    = 1'b0;
        end

        // Empty string: two quotes only
        if (i_in.data.empty_string) begin
            w_open    = 1'b1;
            w_close   = 1'b1;
            w_mid_len = 3'd0;
            n_acc     = 16'h0;
            n_cl      = 2'd0;
            n_ab      = 1'b0;
        end
    end

    // Pack opening quote, middle bytes and closing quote into the run
    always_comb begin
        w_j     = 4'd0;
        w_total = {3'b0, w_open} + {1'b0, w_mid_len} + {3'b0, w_close};
        for (int i = 0; i < MaxResults; i++) begin
            w_j = 4'(i) - {3'b0, w_open};
            if ((i == 0) && w_open) begin
                w_list[i] = C_QUOTE;
            end else if (w_j < {1'b0, w_mid_len}) begin
                w_list[i] = w_mid[w_j[2:0]];
            end else begin
                w_list[i] = C_QUOTE;
            end
        end
    end

    // Decoder state and run bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= 16'h0;
            r_cl   <= 2'd0;
            r_ab   <= 1'b0;
            r_left <= 4'd0;
            r_pos  <= 3'd0;
            r_ov   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_acc  <= n_acc;
                r_cl   <= n_cl;
                r_ab   <= n_ab;
                r_left <= w_total;
                r_pos  <= 3'd0;
            end else if (w_move) begin
                r_left <= r_left - 4'd1;
                r_pos  <= r_pos + 3'd1;
            end
            if (w_move) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload: load the run and advance the output register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_list  <= w_list;
            r_close <= w_close;
        end
        if (w_move) begin
            r_out.out_byte   <= r_list[r_pos];
            r_out.run_end    <= (r_left == 4'd1);
            r_out.string_end <= r_close && (r_left == 4'd1);
        end
    end

`include "assert_macros.svh"

    `ASSERT_SAME(a_string_end_is_run_end, r_ov && r_out.string_end, r_out.run_end)
    `ASSERT_NEXT(a_drain_counts_down, w_move && !w_accept, r_left == $past(r_left) - 4'd1)
    `ASSERT_NEXT(a_close_clears_state,
        w_accept && (i_in.data.last_byte || i_in.data.empty_string),
        (r_acc == 16'h0) && (r_cl == 2'd0) && !r_ab)
    `ASSERT_SAME(a_run_fits, r_left != 4'd0, ({1'b0, r_pos} + r_left) <= 4'd8)

endmodule
